// File: rtl/core/mbrs_pkg.sv
// shared types and constants for the modbus tcp register read server
// no dependencies; every other file refers to this package by scoped names
package mbrs_pkg;

    localparam int HDR_LEN   = 7;
    localparam int PDU_KEEP  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int REG_IDX_W = 5;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_ABORT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

    localparam logic [7:0] FC_READ  = 8'h03;
    localparam logic [7:0] EXC_FLAG = 8'h80;
    localparam logic [7:0] EXC_ADDR = 8'h02;
    localparam logic [7:0] EXC_FUNC = 8'h01;
    localparam logic [7:0] MIN_LEN  = 8'd2;

    typedef enum logic [9:0] {
        S_RX      = 10'b00_0000_0001,
        S_BAD     = 10'b00_0000_0010,
        S_EVAL    = 10'b00_0000_0100,
        S_HDR     = 10'b00_0000_1000,
        S_EXC_FC  = 10'b00_0001_0000,
        S_EXC_CD  = 10'b00_0010_0000,
        S_BCNT    = 10'b00_0100_0000,
        S_RD      = 10'b00_1000_0000,
        S_HI      = 10'b01_0000_0000,
        S_LO      = 10'b10_0000_0000
    } t_state;

    // access request from the frame engine to the register table
    typedef struct packed {
        logic                 wr_en;
        logic [REG_IDX_W-1:0] wr_idx;
        logic [15:0]          wr_data;
        logic                 rd_en;
        logic [REG_IDX_W-1:0] rd_idx;
    } t_tbl_req;

endpackage

// File: rtl/core/mbrs_if.sv
// valid/ready channel interfaces: request items, response bytes, register writes
// depends on mbrs_pkg for the config index width
interface mbrs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;

    modport source (output valid, opcode, rx_byte, reg_index, reg_value, input ready);
    modport sink   (input valid, opcode, rx_byte, reg_index, reg_value, output ready);
endinterface

interface mbrs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last;
    logic       bad_frame;

    modport source (output valid, tx_byte, last, bad_frame, input ready);
    modport sink   (input valid, tx_byte, last, bad_frame, output ready);
endinterface

interface mbrs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mbrs_pkg::CFG_IDX_W-1:0] index;
    logic [15:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/mbrs_table.sv
// holding register table: synchronous memory, one write and one read port,
// registered read data; per-entry valid bits make unwritten entries read as zero
module mbrs_table #(
    parameter int MAX_REGS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbrs_pkg::t_tbl_req i_req,
    output logic [15:0]        o_rdata
);
    localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

    logic [15:0]         r_mem [MAX_REGS];
    logic [MAX_REGS-1:0] r_vld;
    logic [15:0]         r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_idx[AW-1:0]] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_vld[i_req.rd_idx[AW-1:0]] ? r_mem[i_req.rd_idx[AW-1:0]] : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_idx[AW-1:0]] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/modbus_tcp_register_read_server.sv
// Modbus TCP read-holding-registers server. While idle it takes one item per cycle: a
// request byte, a write to the MAX_REGS-entry holding register table, or an abort that
// drops a partial frame. A header with a nonzero protocol id or a length outside 2..255
// gives a single bad_frame beat. A complete frame passes the range check,
// then streams its response while input is held off: 7 header bytes, then either the
// two exception bytes or a byte count and, per register, a read of the table memory,
// then its high and low byte. The table comes out of reset reading zero. Depends on
// mbrs_pkg, mbrs_if and mbrs_table.
module modbus_tcp_register_read_server #(
    parameter int MAX_REGS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbrs_in_if.sink     i_in,
    mbrs_cfg_if.sink    i_cfg,
    mbrs_out_if.source  o_out
);
    localparam int RW = mbrs_pkg::REG_IDX_W;

    mbrs_pkg::t_state   r_state, n_state;
    mbrs_pkg::t_tbl_req tbl_req;
    logic [15:0]        tbl_rdata;

    logic [7:0]  r_hdr [mbrs_pkg::HDR_LEN];
    logic [7:0]  r_pdu [mbrs_pkg::PDU_KEEP];
    logic [7:0]  r_cnt;
    logic [7:0]  r_plen;
    logic        r_phase;
    logic [15:0] r_base;
    logic [4:0]  r_rcnt;

    logic        r_ok;
    logic [7:0]  r_len5;
    logic [7:0]  r_code;
    logic [RW-1:0] r_idx;
    logic [RW-1:0] r_left;
    logic [2:0]  r_hpos;

    logic        r_ov;
    logic [7:0]  r_tx;
    logic        r_last;
    logic        r_bad;

    logic        in_fire;
    logic        out_free;
    logic        emit;
    logic [7:0]  e_byte;
    logic        e_last;
    logic        e_bad;
    logic        hdr_bad;

    // range check operands
    logic [15:0] addr, qty;
    logic [4:0]  limit;
    logic [16:0] span_end, table_end;
    logic        read_req, range_ok;

    mbrs_table #(.MAX_REGS(MAX_REGS)) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tbl_req),
        .o_rdata (tbl_rdata)
    );

    assign i_in.ready  = (r_state == mbrs_pkg::S_RX);
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_ov || o_out.ready;

    assign o_out.valid     = r_ov;
    assign o_out.tx_byte   = r_tx;
    assign o_out.last      = r_last;
    assign o_out.bad_frame = r_bad;

    assign hdr_bad = ({r_hdr[2], r_hdr[3]} != 16'd0) || (r_hdr[4] != 8'd0)
                   || (r_hdr[5] < mbrs_pkg::MIN_LEN);

    assign addr      = {r_pdu[1], r_pdu[2]};
    assign qty       = {r_pdu[3], r_pdu[4]};
    assign limit     = (r_rcnt > 5'(MAX_REGS)) ? 5'(MAX_REGS) : r_rcnt;
    assign span_end  = {1'b0, addr} + {1'b0, qty};
    assign table_end = {1'b0, r_base} + {12'd0, limit};
    assign read_req  = (r_pdu[0] == mbrs_pkg::FC_READ) && (r_plen == 8'(mbrs_pkg::PDU_KEEP));
    assign range_ok  = read_req && (qty != 16'd0) && (addr >= r_base)
                     && (span_end <= table_end);

    always_comb begin
        n_state = r_state;
        emit    = 1'b0;
        e_byte  = 8'd0;
        e_last  = 1'b0;
        e_bad   = 1'b0;
        tbl_req = '0;
        case (r_state)
            mbrs_pkg::S_RX: begin
                if (in_fire) begin
                    case (i_in.opcode)
                        mbrs_pkg::OP_WRITE: begin
                            tbl_req.wr_en   = ({1'b0, i_in.reg_index} < 5'(MAX_REGS));
                            tbl_req.wr_idx  = RW'({1'b0, i_in.reg_index});
                            tbl_req.wr_data = i_in.reg_value;
                        end
                        mbrs_pkg::OP_BYTE: begin
                            if (!r_phase) begin
                                if (r_cnt == 8'(mbrs_pkg::HDR_LEN - 1) && hdr_bad) begin
                                    n_state = mbrs_pkg::S_BAD;
                                end
                            end else if (r_cnt + 8'd1 == r_plen) begin
                                n_state = mbrs_pkg::S_EVAL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mbrs_pkg::S_BAD: begin
                emit   = out_free;
                e_last = 1'b1;
                e_bad  = 1'b1;
                if (out_free) n_state = mbrs_pkg::S_RX;
            end
            mbrs_pkg::S_EVAL: begin
                n_state = mbrs_pkg::S_HDR;
            end
            mbrs_pkg::S_HDR: begin
                emit = out_free;
                case (r_hpos)
                    3'd4:    e_byte = 8'd0;
                    3'd5:    e_byte = r_len5;
                    default: e_byte = r_hdr[r_hpos];
                endcase
                if (out_free && r_hpos == 3'(mbrs_pkg::HDR_LEN - 1)) begin
                    n_state = r_ok ? mbrs_pkg::S_BCNT : mbrs_pkg::S_EXC_FC;
                end
            end
            mbrs_pkg::S_EXC_FC: begin
                emit   = out_free;
                e_byte = r_pdu[0] | mbrs_pkg::EXC_FLAG;
                if (out_free) n_state = mbrs_pkg::S_EXC_CD;
            end
            mbrs_pkg::S_EXC_CD: begin
                emit   = out_free;
                e_byte = r_code;
                e_last = 1'b1;
                if (out_free) n_state = mbrs_pkg::S_RX;
            end
            mbrs_pkg::S_BCNT: begin
                emit   = out_free;
                e_byte = 8'({r_left, 1'b0});
                if (out_free) n_state = mbrs_pkg::S_RD;
            end
            mbrs_pkg::S_RD: begin
                tbl_req.rd_en  = 1'b1;
                tbl_req.rd_idx = r_idx;
                n_state        = mbrs_pkg::S_HI;
            end
            mbrs_pkg::S_HI: begin
                emit   = out_free;
                e_byte = tbl_rdata[15:8];
                if (out_free) n_state = mbrs_pkg::S_LO;
            end
            mbrs_pkg::S_LO: begin
                emit   = out_free;
                e_byte = tbl_rdata[7:0];
                e_last = (r_left == RW'(1));
                if (out_free) n_state = (r_left == RW'(1)) ? mbrs_pkg::S_RX : mbrs_pkg::S_RD;
            end
            default: begin
                n_state = mbrs_pkg::S_RX;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbrs_pkg::S_RX;
            r_cnt   <= 8'd0;
            r_phase <= 1'b0;
            r_plen  <= 8'd0;
            r_base  <= 16'd0;
            r_rcnt  <= 5'd0;
            r_ov    <= 1'b0;
            r_hpos  <= 3'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    mbrs_pkg::CFG_BASE:  r_base <= i_cfg.data;
                    mbrs_pkg::CFG_COUNT: r_rcnt <= i_cfg.data[4:0];
                    default: begin
                    end
                endcase
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == mbrs_pkg::S_EVAL) begin
                r_hpos <= 3'd0;
            end else if (r_state == mbrs_pkg::S_HDR && out_free) begin
                r_hpos <= r_hpos + 3'd1;
            end
            if (in_fire) begin
                case (i_in.opcode)
                    mbrs_pkg::OP_ABORT: begin
                        r_phase <= 1'b0;
                        r_cnt   <= 8'd0;
                    end
                    mbrs_pkg::OP_BYTE: begin
                        if (!r_phase) begin
                            if (r_cnt == 8'(mbrs_pkg::HDR_LEN - 1)) begin
                                r_cnt <= 8'd0;
                                if (!hdr_bad) begin
                                    r_phase <= 1'b1;
                                    r_plen  <= r_hdr[5] - 8'd1;
                                end
                            end else begin
                                r_cnt <= r_cnt + 8'd1;
                            end
                        end else if (r_cnt + 8'd1 == r_plen) begin
                            r_cnt   <= 8'd0;
                            r_phase <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 8'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // frame bytes, response bookkeeping and the output beat register
    always_ff @(posedge i_clk) begin
        if (in_fire && i_in.opcode == mbrs_pkg::OP_BYTE) begin
            if (!r_phase) begin
                r_hdr[r_cnt[2:0]] <= i_in.rx_byte;
            end else if (r_cnt < 8'(mbrs_pkg::PDU_KEEP)) begin
                r_pdu[r_cnt[2:0]] <= i_in.rx_byte;
            end
        end
        if (r_state == mbrs_pkg::S_EVAL) begin
            r_ok   <= range_ok;
            r_len5 <= range_ok ? 8'd3 + {qty[6:0], 1'b0} : 8'd3;
            r_code <= read_req ? mbrs_pkg::EXC_ADDR : mbrs_pkg::EXC_FUNC;
            r_idx  <= RW'(addr - r_base);
            r_left <= RW'(qty);
        end else if (r_state == mbrs_pkg::S_LO && out_free) begin
            r_idx  <= r_idx + RW'(1);
            r_left <= r_left - RW'(1);
        end
        if (emit) begin
            r_tx   <= e_byte;
            r_last <= e_last;
            r_bad  <= e_bad;
        end
    end

`ifndef SYNTHESIS
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.bad_frame) |-> o_out.last)
        else $error("bad frame notice without last");
    a_hdr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_phase |-> (r_cnt < 8'(mbrs_pkg::HDR_LEN)))
        else $error("header byte count overran");
    a_pdu_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase && r_state == mbrs_pkg::S_RX) |-> (r_cnt < r_plen))
        else $error("pdu byte count passed frame length");
    a_words_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mbrs_pkg::S_RD || r_state == mbrs_pkg::S_LO) |-> (r_left != RW'(0)))
        else $error("register walk with no words left");
`endif

endmodule
